[hw/rtl/bcip_pkg.sv]
// Package with shared widths, types and constants of the box corner image projector.
`default_nettype none
package bcip_pkg;

  localparam int IN_W    = 16;
  localparam int COEF_W  = 21;
  localparam int NCOEF   = 12;
  localparam int WORD_W  = 63;
  localparam int LIM_W   = 12;
  localparam int OUT_W   = 20;
  localparam int PROD_W  = COEF_W + IN_W;
  localparam int ACC_W   = 40;
  localparam int NUM_W   = ACC_W + 4;
  localparam int QBITS   = 20;
  localparam int DIV_W   = NUM_W + QBITS;
  // Product stage, sum stage, divider input stage, one stage per quotient bit, result stage.
  localparam int LANE_LAT = 3 + QBITS + 1;
  localparam int IDX_W   = 4;

  localparam logic signed [OUT_W-1:0] OUT_MAX = 20'sd524287;
  localparam logic signed [OUT_W-1:0] OUT_MIN = -20'sd524288;

  localparam logic [LIM_W-1:0] LIM_X_HIGH_RST = 12'd1279;
  localparam logic [LIM_W-1:0] LIM_Y_HIGH_RST = 12'd719;

  typedef enum logic [IDX_W-1:0] {
    REG_MATRIX_A = 4'd0,
    REG_MATRIX_B = 4'd1,
    REG_MATRIX_C = 4'd2,
    REG_MATRIX_D = 4'd3,
    REG_LIM_XLO  = 4'd4,
    REG_LIM_YLO  = 4'd5,
    REG_LIM_XHI  = 4'd6,
    REG_LIM_YHI  = 4'd7
  } bcip_reg_t;

  typedef logic [NCOEF-1:0][COEF_W-1:0] bcip_matrix_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] u;
    logic signed [OUT_W-1:0] v;
    logic                    fault;
  } bcip_corner_t;

  typedef struct packed {
    logic [LIM_W-1:0] x_low;
    logic [LIM_W-1:0] y_low;
    logic [LIM_W-1:0] x_high;
    logic [LIM_W-1:0] y_high;
  } bcip_limits_t;

endpackage
`default_nettype wire

[hw/rtl/bcip_div.sv]
// Pipelined signed divider, one quotient bit per stage, saturating to 20 bits.
`default_nettype none
module bcip_div (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire logic signed [bcip_pkg::NUM_W-1:0] num,
  input  wire logic signed [bcip_pkg::ACC_W-1:0] den,
  output logic signed [bcip_pkg::OUT_W-1:0]      quo,
  output logic                                   fault
);
  import bcip_pkg::*;

  logic [NUM_W-1:0] rem  [0:QBITS];
  logic [QBITS-1:0] q    [0:QBITS];
  logic [ACC_W-1:0] dmag [0:QBITS];
  logic             neg  [0:QBITS];
  logic             nneg [0:QBITS];
  logic             nzr  [0:QBITS];
  logic             dzr  [0:QBITS];
  logic             ovf  [1:QBITS];

  // Input stage: magnitudes and signs.
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      dmag[0] <= den[ACC_W-1] ? ACC_W'(-den) : ACC_W'(den);
      q[0]    <= '0;
      neg[0]  <= num[NUM_W-1] ^ den[ACC_W-1];
      nneg[0] <= num[NUM_W-1];
      nzr[0]  <= (num == '0);
      dzr[0]  <= (den == '0);
    end
  end

  for (genvar k = 0; k < QBITS; k++) begin : g_step
    logic [DIV_W-1:0] wrem;
    logic [DIV_W-1:0] dsh;
    logic             ge;
    assign wrem = DIV_W'(rem[k]);
    assign dsh  = DIV_W'(dmag[k]) << (QBITS - 1 - k);
    assign ge   = (wrem >= dsh);
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= ge ? NUM_W'(wrem - dsh) : rem[k];
        q[k+1]    <= {q[k][QBITS-2:0], ge};
        dmag[k+1] <= dmag[k];
        neg[k+1]  <= neg[k];
        nneg[k+1] <= nneg[k];
        nzr[k+1]  <= nzr[k];
        dzr[k+1]  <= dzr[k];
      end
    end
    if (k == 0) begin : g_ovf0
      // Quotient magnitude of 2^20 or more can never fit.
      always_ff @(posedge clk) begin
        if (en) begin
          ovf[1] <= (wrem >= (DIV_W'(dmag[0]) << QBITS));
        end
      end
    end else begin : g_ovfn
      always_ff @(posedge clk) begin
        if (en) begin
          ovf[k+1] <= ovf[k];
        end
      end
    end
  end

  logic signed [OUT_W-1:0] res;
  always_comb begin
    if (dzr[QBITS]) begin
      if (nzr[QBITS]) res = '0;
      else if (nneg[QBITS]) res = OUT_MIN;
      else res = OUT_MAX;
    end else if (ovf[QBITS]) begin
      res = neg[QBITS] ? OUT_MIN : OUT_MAX;
    end else if (neg[QBITS]) begin
      if (q[QBITS] > QBITS'(524288)) res = OUT_MIN;
      else res = OUT_W'(-$signed({1'b0, q[QBITS]}));
    end else begin
      if (q[QBITS] > QBITS'(524287)) res = OUT_MAX;
      else res = $signed(q[QBITS]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo   <= res;
      fault <= dzr[QBITS];
    end
  end
endmodule
`default_nettype wire

[hw/rtl/bcip_lane.sv]
// One corner lane: matrix products, row sums and two divides by the depth row.
`default_nettype none
module bcip_lane (
  input  wire logic                             clk,
  input  wire logic                             en,
  input  wire bcip_pkg::bcip_matrix_t           matrix,
  input  wire logic signed [bcip_pkg::IN_W-1:0] px,
  input  wire logic signed [bcip_pkg::IN_W-1:0] py,
  input  wire logic signed [bcip_pkg::IN_W-1:0] pz,
  output bcip_pkg::bcip_corner_t                corner
);
  import bcip_pkg::*;

  logic signed [PROD_W-1:0] prod [0:2][0:3];
  logic signed [ACC_W-1:0]  acc  [0:2];
  logic                     fu, fv;

  for (genvar r = 0; r < 3; r++) begin : g_row
    always_ff @(posedge clk) begin
      if (en) begin
        prod[r][0] <= $signed(matrix[4*r])   * px;
        prod[r][1] <= $signed(matrix[4*r+1]) * py;
        prod[r][2] <= $signed(matrix[4*r+2]) * pz;
        prod[r][3] <= PROD_W'($signed({matrix[4*r+3], 8'b0}));
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        acc[r] <= ACC_W'(prod[r][0]) + ACC_W'(prod[r][1])
                + ACC_W'(prod[r][2]) + ACC_W'(prod[r][3]);
      end
    end
  end

  bcip_div u_div_u (
    .clk   (clk),
    .en    (en),
    .num   ($signed({acc[0], 4'b0})),
    .den   (acc[2]),
    .quo   (corner.u),
    .fault (fu)
  );

  bcip_div u_div_v (
    .clk   (clk),
    .en    (en),
    .num   ($signed({acc[1], 4'b0})),
    .den   (acc[2]),
    .quo   (corner.v),
    .fault (fv)
  );

  assign corner.fault = fu | fv;
endmodule
`default_nettype wire

[hw/rtl/bcip_merge.sv]
// Merge stage: orders the two image points, applies the pixel limits, registers the result.
`default_nettype none
module bcip_merge (
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire bcip_pkg::bcip_corner_t  ca,
  input  wire bcip_pkg::bcip_corner_t  cb,
  input  wire bcip_pkg::bcip_limits_t  lim,
  output logic signed [bcip_pkg::OUT_W-1:0] left,
  output logic signed [bcip_pkg::OUT_W-1:0] top,
  output logic signed [bcip_pkg::OUT_W-1:0] right,
  output logic signed [bcip_pkg::OUT_W-1:0] bottom,
  output logic                              fault
);
  import bcip_pkg::*;

  logic signed [OUT_W-1:0] l, t, r, b;
  logic signed [OUT_W-1:0] xlo, ylo, xhi, yhi;

  assign xlo = $signed({4'b0, lim.x_low, 4'b0});
  assign ylo = $signed({4'b0, lim.y_low, 4'b0});
  assign xhi = $signed({4'b0, lim.x_high, 4'b0});
  assign yhi = $signed({4'b0, lim.y_high, 4'b0});

  always_comb begin
    l = (ca.u > cb.u) ? cb.u : ca.u;
    r = (ca.u > cb.u) ? ca.u : cb.u;
    t = (ca.v > cb.v) ? cb.v : ca.v;
    b = (ca.v > cb.v) ? ca.v : cb.v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      left   <= (l < xlo) ? '0 : l;
      top    <= (t < ylo) ? '0 : t;
      right  <= (r > xhi) ? xhi : r;
      bottom <= (b > yhi) ? yhi : b;
      fault  <= ca.fault | cb.fault;
    end
  end
endmodule
`default_nettype wire

[hw/rtl/box_corner_image_projector_core.sv]
// Top level of the box corner image projector: config registers, corner select, lanes, merge.
//
//   channel   direction  handshake             payload
//   input     in         in_valid / in_stall   x_min x_max y_min y_max z_min z_max
//   output    out        out_valid / out_stall pixel_left pixel_top pixel_right
//                                              pixel_bottom depth_fault
//   config    in         wr_en                 wr_index, wr_data
//
// A request is taken every cycle while the output is free. Its result is loaded into the
// output register through 25 register stages: the 20 one-bit stages of each divider
// plus product, sum, divider input, quotient and merge stages.
// Reset clears the valid pipeline and loads the register reset values.
// The whole pipeline advances together; when a finished request waits on out_stall,
// the pipeline holds and in_stall rises, and it resumes as soon as the result is taken.
`default_nettype none
module box_corner_image_projector_core (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic signed [bcip_pkg::IN_W-1:0]  x_min,
  input  wire logic signed [bcip_pkg::IN_W-1:0]  x_max,
  input  wire logic signed [bcip_pkg::IN_W-1:0]  y_min,
  input  wire logic signed [bcip_pkg::IN_W-1:0]  y_max,
  input  wire logic signed [bcip_pkg::IN_W-1:0]  z_min,
  input  wire logic signed [bcip_pkg::IN_W-1:0]  z_max,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [bcip_pkg::OUT_W-1:0]      pixel_left,
  output logic signed [bcip_pkg::OUT_W-1:0]      pixel_top,
  output logic signed [bcip_pkg::OUT_W-1:0]      pixel_right,
  output logic signed [bcip_pkg::OUT_W-1:0]      pixel_bottom,
  output logic                                   depth_fault,
  input  wire logic                              wr_en,
  input  wire logic [bcip_pkg::IDX_W-1:0]        wr_index,
  input  wire logic [bcip_pkg::WORD_W-1:0]       wr_data
);
  import bcip_pkg::*;

  logic [WORD_W-1:0] word [0:3];
  bcip_limits_t      lim;
  bcip_matrix_t      matrix;

  // Configuration registers. Indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) word[i] <= '0;
      lim.x_low  <= '0;
      lim.y_low  <= '0;
      lim.x_high <= LIM_X_HIGH_RST;
      lim.y_high <= LIM_Y_HIGH_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_MATRIX_A: word[0]    <= wr_data;
        REG_MATRIX_B: word[1]    <= wr_data;
        REG_MATRIX_C: word[2]    <= wr_data;
        REG_MATRIX_D: word[3]    <= wr_data;
        REG_LIM_XLO:  lim.x_low  <= wr_data[LIM_W-1:0];
        REG_LIM_YLO:  lim.y_low  <= wr_data[LIM_W-1:0];
        REG_LIM_XHI:  lim.x_high <= wr_data[LIM_W-1:0];
        REG_LIM_YHI:  lim.y_high <= wr_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Coefficient k sits in word k/3 at bit 21*(k%3).
  for (genvar k = 0; k < NCOEF; k++) begin : g_coef
    assign matrix[k] = word[k/3][COEF_W*(k%3) +: COEF_W];
  end

  // Pipeline control: everything moves when the output register is empty or taken.
  logic adv, accept;
  logic [LANE_LAT-1:0] vpipe;

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;
  assign accept   = in_valid && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe     <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vpipe     <= {vpipe[LANE_LAT-2:0], accept};
      out_valid <= vpipe[LANE_LAT-1];
    end
  end

  // Sign cases: rows by z, columns by y. A box with z wholly at or above zero and y
  // wholly negative, or with z wholly negative and y wholly at or above zero, pairs
  // the small y with the small x and z; every other box takes the crossed pairing.
  logic z_row0, z_row1, y_col0, y_col1, diag;
  assign z_row0 = !z_min[IN_W-1] && !z_max[IN_W-1];
  assign z_row1 = !z_row0 && !z_max[IN_W-1];
  assign y_col0 = !y_min[IN_W-1] && !y_max[IN_W-1];
  assign y_col1 = !y_col0 && !y_max[IN_W-1];
  assign diag   = (z_row0 && !y_col0 && !y_col1) || (!z_row0 && !z_row1 && y_col0);

  bcip_corner_t ca, cb;

  bcip_lane u_lane_a (
    .clk    (clk),
    .en     (adv),
    .matrix (matrix),
    .px     (x_min),
    .py     (diag ? y_min : y_max),
    .pz     (z_min),
    .corner (ca)
  );

  bcip_lane u_lane_b (
    .clk    (clk),
    .en     (adv),
    .matrix (matrix),
    .px     (x_max),
    .py     (diag ? y_max : y_min),
    .pz     (z_max),
    .corner (cb)
  );

  bcip_merge u_merge (
    .clk    (clk),
    .en     (adv),
    .ca     (ca),
    .cb     (cb),
    .lim    (lim),
    .left   (pixel_left),
    .top    (pixel_top),
    .right  (pixel_right),
    .bottom (pixel_bottom),
    .fault  (depth_fault)
  );
endmodule
`default_nettype wire

[hw/rtl/bcip_checker.sv]
// Port level checker for the box corner image projector, bound to the top level.
`default_nettype none
module bcip_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [19:0] pixel_left,
  input wire logic [19:0] pixel_top,
  input wire logic [19:0] pixel_right,
  input wire logic [19:0] pixel_bottom,
  input wire logic        depth_fault
);
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(pixel_left) && $stable(pixel_top)
      && $stable(pixel_right) && $stable(pixel_bottom) && $stable(depth_fault))
    else $error("stalled result changed");

  a_free_input: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall) else $error("input stalled with empty output");

  a_min_edges: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !pixel_left[19] && !pixel_top[19]) else $error("negative min edge");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid) else $error("result valid after reset");
endmodule

bind box_corner_image_projector_core bcip_checker u_bcip_checker (
  .clk          (clk),
  .rst          (rst),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .pixel_left   (pixel_left),
  .pixel_top    (pixel_top),
  .pixel_right  (pixel_right),
  .pixel_bottom (pixel_bottom),
  .depth_fault  (depth_fault)
);
`default_nettype wire

[bench/box_corner_image_projector_checker.sv]
// Checker that predicts projected image boxes and compares them with the block's results.
`timescale 1ns / 1ps
`default_nettype none
module box_corner_image_projector_checker (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  input  wire logic                              in_stall,
  input  wire logic signed [bcip_pkg::IN_W-1:0]  x_min,
  input  wire logic signed [bcip_pkg::IN_W-1:0]  x_max,
  input  wire logic signed [bcip_pkg::IN_W-1:0]  y_min,
  input  wire logic signed [bcip_pkg::IN_W-1:0]  y_max,
  input  wire logic signed [bcip_pkg::IN_W-1:0]  z_min,
  input  wire logic signed [bcip_pkg::IN_W-1:0]  z_max,
  input  wire logic                              out_valid,
  input  wire logic                              out_stall,
  input  wire logic signed [bcip_pkg::OUT_W-1:0] pixel_left,
  input  wire logic signed [bcip_pkg::OUT_W-1:0] pixel_top,
  input  wire logic signed [bcip_pkg::OUT_W-1:0] pixel_right,
  input  wire logic signed [bcip_pkg::OUT_W-1:0] pixel_bottom,
  input  wire logic                              depth_fault,
  input  wire logic                              wr_en,
  input  wire logic [bcip_pkg::IDX_W-1:0]        wr_index,
  input  wire logic [bcip_pkg::WORD_W-1:0]       wr_data,
  output int                                     fail_count,
  output int                                     pending_count
);
  import bcip_pkg::*;

  typedef struct packed {
    logic signed [OUT_W-1:0] left;
    logic signed [OUT_W-1:0] top;
    logic signed [OUT_W-1:0] right;
    logic signed [OUT_W-1:0] bottom;
    logic                    fault;
  } image_box_t;

  logic [WORD_W-1:0] mat_word [4];
  logic [LIM_W-1:0]  lim_xlo, lim_ylo, lim_xhi, lim_yhi;
  image_box_t        box_queue [$];

  function automatic longint coeff(int k);
    logic [WORD_W-1:0]  w;
    logic signed [20:0] c;
    w = mat_word[k / 3];
    c = w[21 * (k % 3) +: 21];
    return longint'(c);
  endfunction

  function automatic longint sat_out(longint v);
    if (v > 524287) return 524287;
    if (v < -524288) return -524288;
    return v;
  endfunction

  // Projects one corner; returns 1 when the depth row sums to zero.
  function automatic bit corner_to_pixel(longint x, longint y, longint z,
                                         output longint u, output longint v);
    longint acc [3];
    longint num, q;
    bit     zero_depth;
    zero_depth = 0;
    for (int r = 0; r < 3; r++)
      acc[r] = coeff(4*r) * x + coeff(4*r+1) * y + coeff(4*r+2) * z + coeff(4*r+3) * 256;
    for (int r = 0; r < 2; r++) begin
      num = acc[r] * 16;
      if (acc[2] == 0) begin
        zero_depth = 1;
        q = num > 0 ? 524287 : (num < 0 ? -524288 : 0);
      end else begin
        q = sat_out(num / acc[2]);
      end
      if (r == 0) u = q; else v = q;
    end
    return zero_depth;
  endfunction

  function automatic int sign_case(longint ylo, longint yhi, longint zlo, longint zhi);
    int row, col;
    if (zlo >= 0 && zhi >= 0) row = 0;
    else if (zlo <= 0 && zhi >= 0) row = 1;
    else row = 2;
    if (ylo >= 0 && yhi >= 0) col = 0;
    else if (ylo <= 0 && yhi >= 0) col = 1;
    else col = 2;
    return row * 3 + col;
  endfunction

  function automatic image_box_t project_box(longint xa, longint xb, longint ya,
                                             longint yb, longint za, longint zb);
    longint     l, t, r, b, tmp;
    bit         f;
    int         sc;
    image_box_t res;
    sc = sign_case(ya, yb, za, zb);
    // Two of the sign cases use the main diagonal; the rest the cross diagonal.
    if (sc == 2 || sc == 6) begin
      f = corner_to_pixel(xa, ya, za, l, t);
      f = corner_to_pixel(xb, yb, zb, r, b) | f;
    end else begin
      f = corner_to_pixel(xa, yb, za, l, t);
      f = corner_to_pixel(xb, ya, zb, r, b) | f;
    end
    if (l > r) begin tmp = l; l = r; r = tmp; end
    if (t > b) begin tmp = t; t = b; b = tmp; end
    if (t < longint'(lim_ylo) * 16) t = 0;
    if (l < longint'(lim_xlo) * 16) l = 0;
    if (b > longint'(lim_yhi) * 16) b = longint'(lim_yhi) * 16;
    if (r > longint'(lim_xhi) * 16) r = longint'(lim_xhi) * 16;
    res.left = l[OUT_W-1:0];
    res.top = t[OUT_W-1:0];
    res.right = r[OUT_W-1:0];
    res.bottom = b[OUT_W-1:0];
    res.fault = f;
    return res;
  endfunction

  assign pending_count = box_queue.size();

  always @(posedge clk) begin
    image_box_t want, got;
    if (rst) begin
      for (int i = 0; i < 4; i++) mat_word[i] <= '0;
      lim_xlo <= '0;
      lim_ylo <= '0;
      lim_xhi <= LIM_X_HIGH_RST;
      lim_yhi <= LIM_Y_HIGH_RST;
      fail_count <= 0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_MATRIX_A: mat_word[0] <= wr_data;
          REG_MATRIX_B: mat_word[1] <= wr_data;
          REG_MATRIX_C: mat_word[2] <= wr_data;
          REG_MATRIX_D: mat_word[3] <= wr_data;
          REG_LIM_XLO:  lim_xlo <= wr_data[LIM_W-1:0];
          REG_LIM_YLO:  lim_ylo <= wr_data[LIM_W-1:0];
          REG_LIM_XHI:  lim_xhi <= wr_data[LIM_W-1:0];
          REG_LIM_YHI:  lim_yhi <= wr_data[LIM_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        box_queue = {box_queue, project_box(x_min, x_max, y_min, y_max, z_min, z_max)};
      if (out_valid && !out_stall) begin
        got = '{pixel_left, pixel_top, pixel_right, pixel_bottom, depth_fault};
        if (box_queue.size() == 0) begin
          if (fail_count < 10) $display("ERROR: unexpected result %p", got);
          fail_count <= fail_count + 1;
        end else begin
          want = box_queue.pop_front();
          if (want !== got) begin
            if (fail_count < 10)
              $display("ERROR: mismatch expected %p actual %p", want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

[bench/box_corner_image_projector_core_test.sv]
// Top of the box corner image projector testbench: stimulus, register writes and verdict.
`timescale 1ns / 1ps
`default_nettype none
module box_corner_image_projector_core_test;
  import bcip_pkg::*;

  localparam int RANDOM_ITEMS = 1130;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = LANE_LAT + 10;

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  logic signed [IN_W-1:0]  x_min, x_max, y_min, y_max, z_min, z_max;
  logic signed [OUT_W-1:0] pixel_left, pixel_top, pixel_right, pixel_bottom;
  logic depth_fault;
  logic wr_en;
  logic [IDX_W-1:0]  wr_index;
  logic [WORD_W-1:0] wr_data;
  int fail_count, pending_count;
  int idle_cycles;
  bit calm_phase;

  box_corner_image_projector_core uut (.*);
  box_corner_image_projector_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // The receiver stalls in random bursts, except at the end.
  initial begin
    int burst;
    out_stall = 0;
    forever begin
      @(negedge clk);
      if (!calm_phase && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 5);
        out_stall <= 1;
        repeat (burst) @(negedge clk);
      end
      out_stall <= 0;
    end
  end

  // The watchdog counts cycles in which neither channel completes a transfer.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Writes one register while the pipeline is empty.
  task automatic write_reg(bcip_reg_t idx, logic [WORD_W-1:0] value);
    wr_en = 1;
    wr_index = idx;
    wr_data = value;
    @(negedge clk);
    wr_en = 0;
  endtask

  // Waits until every expected result is back and the lanes have drained.
  task automatic drain();
    in_valid = 0;
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [WORD_W-1:0] pack3(int a, int b, int c);
    logic [20:0] ca, cb, cc;
    ca = 21'(a);
    cb = 21'(b);
    cc = 21'(c);
    return {cc, cb, ca};
  endfunction

  // Loads a plausible camera: focal terms on y for u and on z for v, depth follows forward x.
  task automatic load_camera(int f, int cu, int cv, int depth_off);
    write_reg(REG_MATRIX_A, pack3(cu, -f, 0));
    write_reg(REG_MATRIX_B, pack3(0, cv, 0));
    write_reg(REG_MATRIX_C, pack3(-f, 0, 256));
    write_reg(REG_MATRIX_D, pack3(0, 0, depth_off));
  endtask

  // Sends one request; the sender idles in random bursts before it. The request is
  // taken at the first rising edge where in_stall is low.
  task automatic send_box(int a, int b, int c, int d, int e, int g);
    if (!calm_phase && $urandom_range(0, 5) == 0) begin
      in_valid = 0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    x_min = 16'(a); x_max = 16'(b); y_min = 16'(c);
    y_max = 16'(d); z_min = 16'(e); z_max = 16'(g);
    in_valid = 1;
    @(posedge clk iff !in_stall);
    @(negedge clk);
  endtask

  // A well-formed box in front of the camera with random spans and signs.
  task automatic send_sensible_box();
    int xa, ya, za;
    xa = $urandom_range(256, 20000);
    ya = int'($urandom_range(0, 8000)) - 4000;
    za = int'($urandom_range(0, 1600)) - 800;
    send_box(xa, xa + $urandom_range(0, 1000), ya, ya + $urandom_range(0, 2000),
             za, za + $urandom_range(0, 1000));
  endtask

  task automatic send_random_box();
    send_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  initial begin
    int sign_pat [3];
    rst = 1;
    calm_phase = 0;
    in_valid = 0;
    wr_en = 0;
    wr_index = '0;
    wr_data = '0;
    {x_min, x_max, y_min, y_max, z_min, z_max} = '0;
    repeat (7) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // With reset registers every depth is zero, so each box reports a fault.
    send_box(16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff, 0, 0);
    drain();

    load_camera(256 * 1000, 256 * 640, 256 * 360, 0);
    write_reg(REG_LIM_XLO, 12'd10);
    write_reg(REG_LIM_YLO, 12'd5);
    write_reg(REG_LIM_XHI, 12'd1279);
    write_reg(REG_LIM_YHI, 12'd719);
    // Each sign case of the z and y extents: both positive, straddling, both negative.
    sign_pat = '{1000, -500, -1500};
    for (int zr = 0; zr < 3; zr++)
      for (int yc = 0; yc < 3; yc++)
        send_box(2560, 5120, sign_pat[yc], sign_pat[yc] + 1000,
                 sign_pat[zr], sign_pat[zr] + 1000);
    // Field extremes, a zero-depth corner, and swapped extents.
    send_box(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
    send_box(0, 0, 0, 0, 0, 0);
    send_box(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
    send_box(-1, 1, -1, 1, -1, 1);
    send_box(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_box(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    drain();

    // Extreme registers: full-scale coefficients, the widest y limits and inverted x limits.
    write_reg(REG_MATRIX_A, {WORD_W{1'b1}});
    write_reg(REG_MATRIX_B, {1'b0, {20{1'b1}}, 1'b1, {20{1'b0}}, 21'h0fffff});
    write_reg(REG_MATRIX_C, {21'h100000, 21'h0fffff, 21'h100000});
    write_reg(REG_MATRIX_D, {21'h0fffff, 21'h100000, 21'h0fffff});
    write_reg(REG_LIM_XLO, 12'hfff);
    write_reg(REG_LIM_YLO, 12'd0);
    write_reg(REG_LIM_XHI, 12'd0);
    write_reg(REG_LIM_YHI, 12'hfff);
    for (int i = 0; i < 6; i++) send_random_box();
    drain();

    // Random phases: each loads new registers, then mostly sensible boxes.
    for (int phase = 0; phase < 5; phase++) begin
      if (phase == 4) calm_phase = 1;
      if (phase % 2 == 0) begin
        load_camera($urandom_range(1000, 400000), $urandom_range(0, 300000),
                    $urandom_range(0, 200000), $urandom_range(0, 2000));
      end else begin
        write_reg(REG_MATRIX_A, WORD_W'({$urandom, $urandom}));
        write_reg(REG_MATRIX_B, WORD_W'({$urandom, $urandom}));
        write_reg(REG_MATRIX_C, WORD_W'({$urandom, $urandom}));
        write_reg(REG_MATRIX_D, WORD_W'({$urandom, $urandom}));
      end
      write_reg(REG_LIM_XLO, $urandom_range(0, 200));
      write_reg(REG_LIM_YLO, $urandom_range(0, 200));
      write_reg(REG_LIM_XHI, $urandom_range(0, 4095));
      write_reg(REG_LIM_YHI, $urandom_range(0, 4095));
      for (int i = 0; i < RANDOM_ITEMS / 5; i++) begin
        if ($urandom_range(0, 3) == 0) send_random_box();
        else send_sensible_box();
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
